[rtl/core/a2bc_pkg.sv]
// Package for the block compression core: payload structs, sizes,
// and the BlaMka helper functions. No dependencies.
package a2bc_pkg;

   localparam int BLOCK_WORDS = 128;
   localparam int SBOX_WORDS  = 1024;
   localparam int SBOX_ROUNDS = 96;

   localparam int WADDR_W = $clog2(BLOCK_WORDS);
   localparam int SADDR_W = $clog2(SBOX_WORDS);
   localparam int PAIR_W  = WADDR_W - 1;
   localparam int RND_W   = (SBOX_ROUNDS > 1) ? $clog2(SBOX_ROUNDS) : 1;
   localparam logic [RND_W-1:0] RND_LAST = RND_W'(SBOX_ROUNDS - 1);
   localparam logic [WADDR_W-1:0] WORD_LAST = WADDR_W'(BLOCK_WORDS - 1);
   localparam logic [PAIR_W-1:0] PAIR_LAST = PAIR_W'(BLOCK_WORDS / 2 - 1);

   localparam logic OP_SBOX  = 1'b0;
   localparam logic OP_BLOCK = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [9:0]  sbox_index;
      logic [63:0] sbox_word;
      logic [63:0] left_word;
      logic [63:0] right_word;
   } req_payload_type;

   typedef struct packed {
      logic [5:0]  pair_index;
      logic [63:0] out_word_even;
      logic [63:0] out_word_odd;
      logic        last;
   } rsp_payload_type;

   // Block address of one slot of quarter-round q within the pass/group
   // selected by qc = {pass, group, quarter}.
   function automatic logic [6:0] quarter_addr(input logic [6:0] qc, input logic [1:0] slot);
      logic [1:0] low;
      logic [2:0] grp;
      logic [6:0] addr;
      low = qc[2] ? (qc[1:0] + slot) : qc[1:0];
      grp = qc[5:3];
      if (qc[6]) begin
         addr = {slot, low[1], grp, low[0]};
      end else begin
         addr = {grp, slot, low};
      end
      return addr;
   endfunction

   function automatic logic [63:0] rotr_by_op(input logic [63:0] v, input logic [2:0] op);
      logic [63:0] r;
      unique case (op[2:1])
         2'd0: r = {v[31:0], v[63:32]};
         2'd1: r = {v[23:0], v[63:24]};
         2'd2: r = {v[15:0], v[63:16]};
         default: r = {v[62:0], v[63]};
      endcase
      return r;
   endfunction

endpackage

[rtl/core/a2bc_mul.sv]
// Shared 32x32 multiplier with registered product.
// Stands alone: no package or module dependencies.
module a2bc_mul (
   input  logic        clock,
   input  logic        mul_en,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] prod_ff
);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= {32'd0, mul_a} * {32'd0, mul_b};
      end
   end

endmodule

[rtl/core/argon2_block_compression_core.sv]
// Argon2 compression G core with optional S-box mixing.
// Depends on a2bc_pkg and a2bc_mul (the shared multiplier).
//
//  channel | ports                            | moves
//  req     | req_valid/req_ready/req_payload  | S-box word or source word pair
//  rsp     | rsp_valid/rsp_ready/rsp_payload  | one pair of output words
//  csr     | csr_we/csr_wdata                 | use_sbox bit
//
// After word 127 the core runs 128 quarter-rounds, each a load, ALU and
// store phase, preceded by 96 rounds of S-box mixing when enabled; each
// output pair is formed in OUT_A_S to OUT_C_S and then held with rsp_valid
// in OUT_W_S until rsp_ready is high. req_ready is low from word 127 until
// the last pair is taken. Reset is synchronous; memory contents are not cleared.
module argon2_block_compression_core import a2bc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_we,
   input  logic            csr_wdata
);

   typedef enum logic [15:0] {
      IDLE_S   = 16'h0001,
      MIX_A_S  = 16'h0002,
      MIX_B_S  = 16'h0004,
      MIX_C_S  = 16'h0008,
      SB_Y_S   = 16'h0010,
      SB_Z_S   = 16'h0020,
      SB_W_S   = 16'h0040,
      QLOAD_S  = 16'h0080,
      QMUL_S   = 16'h0100,
      QADD_S   = 16'h0200,
      QXOR_S   = 16'h0400,
      QSTORE_S = 16'h0800,
      OUT_A_S  = 16'h1000,
      OUT_B_S  = 16'h2000,
      OUT_C_S  = 16'h4000,
      OUT_W_S  = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic use_sbox_ff, use_sbox_in;
   logic [WADDR_W-1:0] wc_ff, wc_in;
   logic [6:0] qc_ff, qc_in;
   logic [2:0] sub_ff, sub_in;
   logic [2:0] op_ff, op_in;
   logic [PAIR_W-1:0] pk_ff, pk_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;
   logic [63:0] w_ff, w_in;
   logic [63:0] y_ff, y_in;
   logic [63:0] mix_ff, mix_in;
   logic [63:0] even_ff, even_in;
   logic [63:0] va_ff, va_in, vb_ff, vb_in, vc_ff, vc_in, vd_ff, vd_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   // memories
   logic [63:0] xor_mem [BLOCK_WORDS];
   logic [63:0] work_mem [BLOCK_WORDS];
   logic [63:0] sbox_mem [SBOX_WORDS];
   logic [63:0] xrd_ff, wrd_ff, srd_ff;
   logic [WADDR_W-1:0] x_ra, w_ra, w_wa;
   logic [SADDR_W-1:0] s_ra;
   logic w_we, x_we, s_we;
   logic [63:0] w_wd, x_wd;

   logic        mul_en;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_ff;

   logic [63:0] x_op, s_op, alu_r, sum_sel;
   logic req_fire;

   a2bc_mul u_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod_ff(prod_ff)
   );

   always_ff @(posedge clock) begin
      if (x_we) begin
         xor_mem[wc_ff] <= x_wd;
      end
      xrd_ff <= xor_mem[x_ra];
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         work_mem[w_wa] <= w_wd;
      end
      wrd_ff <= work_mem[w_ra];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         sbox_mem[req_payload.sbox_index] <= req_payload.sbox_word;
      end
      srd_ff <= sbox_mem[s_ra];
   end

   assign req_ready   = (state_ff == IDLE_S);
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // operand selection for the quarter-round step
   always_comb begin
      unique case (op_ff[1:0])
         2'd0: begin x_op = va_ff; s_op = vb_ff; end
         2'd1: begin x_op = vd_ff; s_op = va_ff; end
         2'd2: begin x_op = vc_ff; s_op = vd_ff; end
         default: begin x_op = vb_ff; s_op = vc_ff; end
      endcase
      unique case (sub_ff[1:0])
         2'd0: sum_sel = va_ff;
         2'd1: sum_sel = vb_ff;
         2'd2: sum_sel = vc_ff;
         default: sum_sel = vd_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      use_sbox_in  = csr_we ? csr_wdata : use_sbox_ff;
      wc_in        = wc_ff;
      qc_in        = qc_ff;
      sub_in       = sub_ff;
      op_in        = op_ff;
      pk_in        = pk_ff;
      rnd_in       = rnd_ff;
      w_in         = w_ff;
      y_in         = y_ff;
      mix_in       = mix_ff;
      even_in      = even_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      vc_in        = vc_ff;
      vd_in        = vd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      x_ra         = '0;
      w_ra         = quarter_addr(qc_ff, sub_ff[1:0]);
      w_wa         = quarter_addr(qc_ff, sub_ff[1:0]);
      w_we         = 1'b0;
      w_wd         = sum_sel;
      x_we         = 1'b0;
      x_wd         = req_payload.left_word ^ req_payload.right_word;
      s_we         = 1'b0;
      s_ra         = {1'b0, w_ff[40:32]};
      mul_en       = 1'b0;
      mul_a        = w_ff[63:32];
      mul_b        = w_ff[31:0];
      alu_r        = '0;

      unique case (state_ff)
         IDLE_S: begin
            if (req_fire) begin
               if (req_payload.opcode == OP_SBOX) begin
                  s_we = 1'b1;
               end else begin
                  x_we = 1'b1;
                  w_we = 1'b1;
                  w_wa = wc_ff;
                  w_wd = x_wd;
                  if (wc_ff == WORD_LAST) begin
                     wc_in  = '0;
                     qc_in  = '0;
                     sub_in = '0;
                     if (use_sbox_ff) begin
                        state_in = MIX_A_S;
                     end else begin
                        mix_in   = '0;
                        state_in = QLOAD_S;
                     end
                  end else begin
                     wc_in = wc_ff + 1'b1;
                  end
               end
            end
         end
         MIX_A_S: begin
            x_ra     = '0;
            state_in = MIX_B_S;
         end
         MIX_B_S: begin
            x_ra     = WORD_LAST;
            w_in     = xrd_ff;
            state_in = MIX_C_S;
         end
         MIX_C_S: begin
            w_in     = w_ff ^ xrd_ff;
            rnd_in   = '0;
            state_in = SB_Y_S;
         end
         SB_Y_S: begin
            mul_en   = 1'b1;
            s_ra     = {1'b0, w_ff[40:32]};
            state_in = SB_Z_S;
         end
         SB_Z_S: begin
            y_in     = srd_ff;
            s_ra     = {1'b1, w_ff[8:0]};
            state_in = SB_W_S;
         end
         SB_W_S: begin
            w_in = (prod_ff + y_ff) ^ srd_ff;
            if (rnd_ff == RND_LAST) begin
               mix_in   = w_in;
               state_in = QLOAD_S;
            end else begin
               rnd_in   = rnd_ff + 1'b1;
               state_in = SB_Y_S;
            end
         end
         QLOAD_S: begin
            // read data is registered and arrives in the state after its address
            unique case (sub_ff)
               3'd1: va_in = wrd_ff;
               3'd2: vb_in = wrd_ff;
               3'd3: vc_in = wrd_ff;
               3'd4: vd_in = wrd_ff;
               default: ;
            endcase
            if (sub_ff == 3'd4) begin
               sub_in   = '0;
               op_in    = '0;
               state_in = QMUL_S;
            end else begin
               sub_in = sub_ff + 1'b1;
            end
         end
         QMUL_S: begin
            mul_en   = 1'b1;
            mul_a    = x_op[31:0];
            mul_b    = s_op[31:0];
            state_in = QADD_S;
         end
         QADD_S, QXOR_S: begin
            if (state_ff == QADD_S) begin
               alu_r    = x_op + s_op + {prod_ff[62:0], 1'b0};
               state_in = QXOR_S;
            end else begin
               alu_r    = rotr_by_op(x_op ^ s_op, op_ff);
               state_in = (op_ff == 3'd7) ? QSTORE_S : QMUL_S;
            end
            unique case (op_ff[1:0])
               2'd0: va_in = alu_r;
               2'd1: vd_in = alu_r;
               2'd2: vc_in = alu_r;
               default: vb_in = alu_r;
            endcase
            op_in = op_ff + 1'b1;
         end
         QSTORE_S: begin
            w_we = 1'b1;
            if (sub_ff == 3'd3) begin
               sub_in = '0;
               qc_in  = qc_ff + 1'b1;
               if (qc_ff == 7'd127) begin
                  pk_in    = '0;
                  state_in = OUT_A_S;
               end else begin
                  state_in = QLOAD_S;
               end
            end else begin
               sub_in = sub_ff + 1'b1;
            end
         end
         OUT_A_S: begin
            w_ra     = {pk_ff, 1'b0};
            x_ra     = {pk_ff, 1'b0};
            state_in = OUT_B_S;
         end
         OUT_B_S: begin
            w_ra     = {pk_ff, 1'b1};
            x_ra     = {pk_ff, 1'b1};
            even_in  = (wrd_ff ^ xrd_ff) + ((pk_ff == '0) ? mix_ff : 64'd0);
            state_in = OUT_C_S;
         end
         OUT_C_S: begin
            rsp_in.pair_index    = pk_ff;
            rsp_in.out_word_even = even_ff;
            rsp_in.out_word_odd  = (wrd_ff ^ xrd_ff) + ((pk_ff == PAIR_LAST) ? mix_ff : 64'd0);
            rsp_in.last          = (pk_ff == PAIR_LAST);
            rsp_valid_in         = 1'b1;
            state_in             = OUT_W_S;
         end
         OUT_W_S: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (pk_ff == PAIR_LAST) begin
                  state_in = IDLE_S;
               end else begin
                  pk_in    = pk_ff + 1'b1;
                  state_in = OUT_A_S;
               end
            end
         end
         default: state_in = IDLE_S;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE_S;
         use_sbox_ff  <= 1'b0;
         wc_ff        <= '0;
         qc_ff        <= '0;
         sub_ff       <= '0;
         op_ff        <= '0;
         pk_ff        <= '0;
         rnd_ff       <= '0;
         mix_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         use_sbox_ff  <= use_sbox_in;
         wc_ff        <= wc_in;
         qc_ff        <= qc_in;
         sub_ff       <= sub_in;
         op_ff        <= op_in;
         pk_ff        <= pk_in;
         rnd_ff       <= rnd_in;
         mix_ff       <= mix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      y_ff    <= y_in;
      even_ff <= even_in;
      va_ff   <= va_in;
      vb_ff   <= vb_in;
      vc_ff   <= vc_in;
      vd_ff   <= vd_in;
      rsp_ff  <= rsp_in;
   end

`ifndef SYNTHESIS
   a_last_frees_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_payload.last |=> req_ready)
      else $error("input not ready after last pair");
   a_next_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last |=> state_ff == OUT_A_S)
      else $error("pair sequence did not advance");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted while output pending");
   a_store_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == QSTORE_S |-> sub_ff < 3'd4)
      else $error("store slot out of range");
`endif

endmodule

[sim/argon2_block_compression_core_tb.sv]
// Testbench for argon2_block_compression_core: drives word pairs and S-box
// transactions, predicts every output pair and compares it field by field.
// Depends on a2bc_pkg and the core RTL only.
`timescale 1ns / 1ps

module argon2_block_compression_core_tb;
   import a2bc_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD = 700;
   localparam int MIX_CYCLE = 5;

   class compression_scoreboard;
      bit mix_enable;
      logic [63:0] sbox_mem[SBOX_WORDS];
      logic [63:0] r_block[BLOCK_WORDS];
      logic [63:0] g_block[BLOCK_WORDS];
      logic [63:0] lane[16];
      int unsigned word_pos;
      rsp_payload_type pending[$];
      int errors;
      int pairs_checked;
      int blocks_done;

      function new();
         mix_enable = 0;
         word_pos = 0;
         errors = 0;
         pairs_checked = 0;
         blocks_done = 0;
      endfunction

      function logic [63:0] blamka_add(input logic [63:0] a, input logic [63:0] b);
         logic [63:0] prod;
         prod = 64'(a[31:0]) * 64'(b[31:0]);
         return a + b + (prod << 1);
      endfunction

      function logic [63:0] rot_right(input logic [63:0] x, input int n);
         return (x >> n) | (x << (64 - n));
      endfunction

      function void mix_quad(input int a, input int b, input int c, input int d);
         lane[a] = blamka_add(lane[a], lane[b]);
         lane[d] = rot_right(lane[d] ^ lane[a], 32);
         lane[c] = blamka_add(lane[c], lane[d]);
         lane[b] = rot_right(lane[b] ^ lane[c], 24);
         lane[a] = blamka_add(lane[a], lane[b]);
         lane[d] = rot_right(lane[d] ^ lane[a], 16);
         lane[c] = blamka_add(lane[c], lane[d]);
         lane[b] = rot_right(lane[b] ^ lane[c], 63);
      endfunction

      function void permute_group(input int pos[16]);
         for (int i = 0; i < 16; i++) lane[i] = g_block[pos[i]];
         mix_quad(0, 4, 8, 12);
         mix_quad(1, 5, 9, 13);
         mix_quad(2, 6, 10, 14);
         mix_quad(3, 7, 11, 15);
         mix_quad(0, 5, 10, 15);
         mix_quad(1, 6, 11, 12);
         mix_quad(2, 7, 8, 13);
         mix_quad(3, 4, 9, 14);
         for (int i = 0; i < 16; i++) g_block[pos[i]] = lane[i];
      endfunction

      function logic [63:0] sbox_rounds(input logic [63:0] seed);
         logic [63:0] w;
         logic [63:0] hi;
         logic [63:0] lo;
         logic [63:0] y;
         logic [63:0] z;
         w = seed;
         for (int r = 0; r < SBOX_ROUNDS; r++) begin
            hi = {32'd0, w[63:32]};
            lo = {32'd0, w[31:0]};
            y = sbox_mem[hi[8:0]];
            z = sbox_mem[SBOX_WORDS / 2 + lo[8:0]];
            w = ((hi * lo) + y) ^ z;
         end
         return w;
      endfunction

      function void compress_block();
         int pos[16];
         logic [63:0] mix;
         rsp_payload_type e;
         g_block = r_block;
         mix = mix_enable ? sbox_rounds(r_block[0] ^ r_block[BLOCK_WORDS - 1]) : 64'd0;
         for (int i = 0; i < 8; i++) begin
            for (int k = 0; k < 16; k++) pos[k] = 16 * i + k;
            permute_group(pos);
         end
         for (int i = 0; i < 8; i++) begin
            for (int k = 0; k < 8; k++) begin
               pos[2 * k] = 2 * i + 16 * k;
               pos[2 * k + 1] = 2 * i + 16 * k + 1;
            end
            permute_group(pos);
         end
         for (int i = 0; i < BLOCK_WORDS; i++) g_block[i] ^= r_block[i];
         g_block[0] += mix;
         g_block[BLOCK_WORDS - 1] += mix;
         for (int k = 0; k < BLOCK_WORDS / 2; k++) begin
            e.pair_index = 6'(k);
            e.out_word_even = g_block[2 * k];
            e.out_word_odd = g_block[2 * k + 1];
            e.last = (k == BLOCK_WORDS / 2 - 1);
            pending.push_back(e);
         end
         blocks_done++;
      endfunction

      function void note_request(input req_payload_type p);
         if (p.opcode == OP_SBOX) begin
            sbox_mem[p.sbox_index] = p.sbox_word;
         end else begin
            r_block[word_pos] = p.left_word ^ p.right_word;
            if (word_pos == BLOCK_WORDS - 1) begin
               word_pos = 0;
               compress_block();
            end else begin
               word_pos++;
            end
         end
      endfunction

      function void check_response(input rsp_payload_type got);
         rsp_payload_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected pair %0d, nothing pending", $time, got.pair_index);
            errors++;
            return;
         end
         e = pending.pop_front();
         pairs_checked++;
         if (got.pair_index !== e.pair_index) begin
            $display("%0t: pair_index expected %0d actual %0d", $time, e.pair_index,
                     got.pair_index);
            errors++;
         end
         if (got.out_word_even !== e.out_word_even) begin
            $display("%0t: pair %0d even word expected %h actual %h", $time, e.pair_index,
                     e.out_word_even, got.out_word_even);
            errors++;
         end
         if (got.out_word_odd !== e.out_word_odd) begin
            $display("%0t: pair %0d odd word expected %h actual %h", $time, e.pair_index,
                     e.out_word_odd, got.out_word_odd);
            errors++;
         end
         if (got.last !== e.last) begin
            $display("%0t: pair %0d last expected %b actual %b", $time, e.pair_index,
                     e.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_payload_type rsp_payload;
   logic csr_we = 0;
   logic csr_wdata = 0;

   compression_scoreboard board = new();
   int cycle_count = 0;
   bit fast_sender = 0;
   bit fast_receiver = 0;
   int sbox_writes = 0;
   // S-box entries the next mixing pass walks through; keep noise off them
   bit reserved[SBOX_WORDS];

   argon2_block_compression_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d pairs outstanding", board.pending.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function req_payload_type rand_noise();
      req_payload_type p;
      p.opcode = OP_SBOX;
      p.sbox_index = 10'($urandom);
      p.sbox_word = rand_word();
      p.left_word = rand_word();
      p.right_word = rand_word();
      return p;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_transaction(input req_payload_type p);
      int gap;
      gap = fast_sender ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      board.note_request(p);
      if (p.opcode == OP_SBOX) sbox_writes++;
      @(negedge clock);
   endtask

   task automatic send_sbox(input int idx, input logic [63:0] value);
      req_payload_type p;
      p = rand_noise();
      p.sbox_index = 10'(idx);
      p.sbox_word = value;
      send_transaction(p);
   endtask

   task automatic send_word(input logic [63:0] left, input logic [63:0] right);
      req_payload_type p;
      p = rand_noise();
      p.opcode = OP_BLOCK;
      p.left_word = left;
      p.right_word = right;
      send_transaction(p);
   endtask

   // Write a closed loop of MIX_CYCLE mixing states into the S-box so the
   // rounds started from seed only read entries written here.
   task automatic build_cycle(output logic [63:0] seed);
      logic [63:0] st[MIX_CYCLE];
      logic [63:0] y;
      logic [63:0] z;
      logic [8:0] base_i;
      logic [8:0] base_j;
      int nxt;
      base_i = 9'($urandom);
      base_j = 9'($urandom);
      for (int s = 0; s < SBOX_WORDS; s++) reserved[s] = 0;
      for (int k = 0; k < MIX_CYCLE; k++) begin
         st[k] = rand_word();
         st[k][40:32] = base_i + 9'(k);
         st[k][8:0] = base_j + 9'(k);
      end
      for (int k = 0; k < MIX_CYCLE; k++) begin
         nxt = (k + 1) % MIX_CYCLE;
         y = rand_word();
         z = (({32'd0, st[k][63:32]} * {32'd0, st[k][31:0]}) + y) ^ st[nxt];
         reserved[int'(st[k][40:32])] = 1;
         reserved[SBOX_WORDS / 2 + int'(st[k][8:0])] = 1;
         send_sbox(int'(st[k][40:32]), y);
         send_sbox(SBOX_WORDS / 2 + int'(st[k][8:0]), z);
      end
      seed = st[0];
   endtask

   // Random block whose first and last words xor to seed; S-box noise
   // lands only on entries the mixing loop does not use.
   task automatic send_block(input bit with_sbox_noise, input logic [63:0] seed);
      logic [63:0] first_xor;
      logic [63:0] left;
      logic [63:0] right;
      int idx;
      first_xor = '0;
      fast_sender = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         if (with_sbox_noise && $urandom_range(0, 9) == 0) begin
            idx = $urandom_range(0, SBOX_WORDS - 1);
            if (!reserved[idx]) send_sbox(idx, rand_word());
         end
         left = rand_word();
         right = rand_word();
         if (i == 0) first_xor = left ^ right;
         if (i == BLOCK_WORDS - 1) right = left ^ first_xor ^ seed;
         send_word(left, right);
      end
      fast_sender = 0;
   endtask

   task automatic drain_results();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mix_enable(input bit value);
      csr_we <= 1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 0;
      board.mix_enable = value;
   endtask

   // Receiver: random stalls, one long hold mid-run.
   initial begin
      int stall;
      bit long_done;
      long_done = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!long_done && board.pairs_checked == 100) begin
            rsp_ready <= 0;
            for (int c = 0; c < LONG_HOLD; c++) @(negedge clock);
            long_done = 1;
         end else begin
            if (board.pairs_checked % 64 == 0) fast_receiver = ($urandom_range(0, 2) == 0);
            stall = fast_receiver ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
               rsp_ready <= 0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         board.check_response(rsp_payload);
         @(negedge clock);
      end
   end

   initial begin
      logic [63:0] seed;
      repeat (7) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      write_mix_enable(0);

      // Directed: table extremes, extreme words, an S-box write mid-block.
      send_sbox(0, '1);
      send_sbox(SBOX_WORDS - 1, '0);
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         if (i == 64) send_sbox(SBOX_WORDS / 2, 64'h8000_0000_0000_0001);
         if (i == 0) send_word('1, '0);
         else if (i == BLOCK_WORDS - 1) send_word('0, '1);
         else if (i == 1) send_word('1, '1);
         else if (i == 2) send_word('0, '0);
         else send_word(64'(i) << (i % 64), ~(64'(i) << 32));
      end
      drain_results();

      write_mix_enable(1);
      build_cycle(seed);
      send_block(1, seed);
      // Offer the next block at once so the long output hold stalls the input.
      build_cycle(seed);
      send_block(1, seed);
      drain_results();

      if (board.pending.size() != 0) board.errors++;
      $display("covered %0d blocks, %0d output pairs, %0d S-box writes",
               board.blocks_done, board.pairs_checked, sbox_writes);
      $display("mixing off and on, directed extremes, one long output stall");
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", board.errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
